FILE: hw/rtl/ttint_pkg.sv
package ttint_pkg;

    // Widths of the item fields.
    localparam int OHMS_W   = 16;
    localparam int TEMP_W   = 7;
    localparam int STATUS_W = 2;

    // The table holds at most this many entries, one every DEG_STEP degrees from 0.
    localparam int KNOWN_ENTRIES       = 25;
    localparam int DEF_TABLE_ENTRIES   = 25;
    localparam int DEF_QUEUE_DEPTH     = 2;
    localparam int SEG_W               = $clog2(KNOWN_ENTRIES);
    localparam int DEG_STEP            = 5;

    // Every resistance difference inside the table fits in DIFF_W bits, and the
    // scaled difference and every multiple of a segment span fit in PROD_W bits.
    localparam int DIFF_W = 13;
    localparam int PROD_W = 16;
    localparam int QUO_W  = $clog2(DEG_STEP + 1);

    typedef enum logic [STATUS_W-1:0] {
        RANGE_OK   = 2'd0,
        RANGE_COLD = 2'd1,
        RANGE_HOT  = 2'd2
    } t_range_status;

    // A classified beat passed from the front to the back.
    typedef struct packed {
        logic [OHMS_W-1:0] ohms;
        logic [SEG_W-1:0]  seg;
        t_range_status     status;
    } t_seg_item;

    // A finished result.
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        t_range_status     status;
    } t_result;

    // Resistance in ohms at each table entry, falling with temperature.
    function automatic logic [OHMS_W-1:0] table_ohms(input logic [SEG_W-1:0] idx);
        logic [OHMS_W-1:0] ohms;
        case (idx)
            5'd0:    ohms = 16'd5743;
            5'd1:    ohms = 16'd4627;
            5'd2:    ohms = 16'd3749;
            5'd3:    ohms = 16'd3053;
            5'd4:    ohms = 16'd2499;
            5'd5:    ohms = 16'd2056;
            5'd6:    ohms = 16'd1700;
            5'd7:    ohms = 16'd1412;
            5'd8:    ohms = 16'd1178;
            5'd9:    ohms = 16'd987;
            5'd10:   ohms = 16'd830;
            5'd11:   ohms = 16'd701;
            5'd12:   ohms = 16'd595;
            5'd13:   ohms = 16'd507;
            5'd14:   ohms = 16'd433;
            5'd15:   ohms = 16'd371;
            5'd16:   ohms = 16'd319;
            5'd17:   ohms = 16'd276;
            5'd18:   ohms = 16'd239;
            5'd19:   ohms = 16'd208;
            5'd20:   ohms = 16'd181;
            5'd21:   ohms = 16'd158;
            5'd22:   ohms = 16'd139;
            5'd23:   ohms = 16'd122;
            5'd24:   ohms = 16'd108;
            default: ohms = '0;
        endcase
        return ohms;
    endfunction

    // Temperature at each table entry.
    function automatic logic [TEMP_W-1:0] table_deg(input logic [SEG_W-1:0] idx);
        logic [TEMP_W-1:0] wide;
        wide = TEMP_W'(idx);
        return TEMP_W'(wide * TEMP_W'(DEG_STEP));
    endfunction

endpackage

FILE: hw/rtl/ttint_fifo.sv
module ttint_fifo
    import ttint_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_en,
    input  logic [W-1:0] i_wr_data,
    output logic         o_full,
    input  logic         i_rd_en,
    output logic         o_empty,
    output logic [W-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire, rd_fire;

    // Writes are refused while full, so a full queue never depends on the read side.
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_fire   = i_wr_en && !o_full;
    assign rd_fire   = i_rd_en && !o_empty;

    // Pointer and fill count update, wrapping at any depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: hw/rtl/ttint_front.sv
module ttint_front
    import ttint_pkg::*;
#(
    parameter int USED_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [OHMS_W-1:0] i_ohms,
    output logic              o_ready,
    output logic              o_valid,
    output t_seg_item         o_item,
    input  logic              i_ready
);

    localparam logic [SEG_W-1:0] LAST = SEG_W'(USED_ENTRIES - 1);

    logic      r_valid, n_valid;
    t_seg_item r_item, n_item;
    logic      take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Range check against both ends, then pick the lowest segment whose lower
    // end lies at or below the input: later matches in the downward scan win.
    always_comb begin
        n_item.ohms   = i_ohms;
        n_item.seg    = '0;
        n_item.status = RANGE_OK;
        if (i_ohms > table_ohms('0)) begin
            n_item.status = RANGE_COLD;
        end else if (i_ohms < table_ohms(LAST)) begin
            n_item.status = RANGE_HOT;
        end
        for (int j = USED_ENTRIES - 1; j >= 1; j--) begin
            if (i_ohms >= table_ohms(SEG_W'(j))) begin
                n_item.seg = SEG_W'(j - 1);
            end
        end
    end

    // Beat valid flag.
    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/ttint_back.sv
module ttint_back
    import ttint_pkg::*;
#(
    parameter int USED_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_seg_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_result   o_result,
    input  logic      i_ready
);

    localparam logic [SEG_W-1:0]  LAST     = SEG_W'(USED_ENTRIES - 1);
    localparam logic [TEMP_W-1:0] HOT_TEMP = table_deg(LAST) + 1'b1;

    // Stage A: scaled offset into the segment and the segment span.
    logic              r_a_valid;
    logic [PROD_W-1:0] r_a_scaled;
    logic [DIFF_W-1:0] r_a_span;
    logic [TEMP_W-1:0] r_a_base;
    t_range_status     r_a_status;
    logic              a_ready;

    // Stage B: finished result.
    logic              r_b_valid;
    t_result           r_b_result;
    logic              b_ready;

    logic [OHMS_W-1:0] hi_ohms, lo_ohms;
    logic [DIFF_W-1:0] off, span;
    logic [PROD_W-1:0] scaled;
    logic [QUO_W-1:0]  quo;
    t_result           n_b_result;

    assign b_ready  = !r_b_valid || i_ready;
    assign a_ready  = !r_a_valid || b_ready;
    assign o_ready  = a_ready;
    assign o_valid  = r_b_valid;
    assign o_result = r_b_result;

    // The offset below the segment's upper resistance is scaled by the
    // temperature step; every segment spans the same number of degrees.
    always_comb begin
        hi_ohms = table_ohms(i_item.seg);
        lo_ohms = table_ohms(i_item.seg + 1'b1);
        off     = DIFF_W'(hi_ohms - i_item.ohms);
        span    = DIFF_W'(hi_ohms - lo_ohms);
        scaled  = PROD_W'(off) * PROD_W'(DEG_STEP);
    end

    // The quotient is at most the step, so it is found by comparing against
    // each multiple of the span. A flat segment gives its first temperature.
    always_comb begin
        quo = '0;
        if (r_a_span != '0) begin
            for (int k = 1; k <= DEG_STEP; k++) begin
                if (r_a_scaled >= PROD_W'(PROD_W'(r_a_span) * PROD_W'(k))) begin
                    quo = quo + 1'b1;
                end
            end
        end
        n_b_result.status = r_a_status;
        case (r_a_status)
            RANGE_COLD: n_b_result.temp = table_deg('0);
            RANGE_HOT:  n_b_result.temp = HOT_TEMP;
            default:    n_b_result.temp = r_a_base + TEMP_W'(quo);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_scaled <= scaled;
            r_a_span   <= span;
            r_a_base   <= table_deg(i_item.seg);
            r_a_status <= i_item.status;
        end
        if (b_ready && r_a_valid) begin
            r_b_result <= n_b_result;
        end
    end

endmodule

FILE: hw/rtl/thermistor_table_interpolator.sv
// Turns a thermistor resistance in ohms into a temperature in whole degrees
// Celsius by linear interpolation, truncated, over a fixed table of falling
// resistances at 5 degree steps from 0 C. A resistance above the first entry
// gives 0 with range_status 1 (cold); one below the last entry in use gives
// the last temperature plus one (121 for the full table) with range_status 2
// (hot); otherwise range_status is 0. TABLE_ENTRIES selects how many entries
// are used, clamped to 2..25. One sample is accepted and one result delivered
// in every cycle, while full stays low and pop is high with a result waiting.
// The sample passes five registers: the front register for range check and
// segment search (loaded at the accepting edge), one in the decoupling queue,
// two back stages for scaling and the quotient compare, and one in the output
// queue. Both queues hold QUEUE_DEPTH beats, two by default.
module thermistor_table_interpolator
    import ttint_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [OHMS_W-1:0]   i_resistance_ohms,
    output logic                empty,
    input  logic                pop,
    output logic [TEMP_W-1:0]   o_temperature_c,
    output logic [STATUS_W-1:0] o_range_status
);

    localparam int USED_ENTRIES = (TABLE_ENTRIES < 2) ? 2 :
                                  (TABLE_ENTRIES > KNOWN_ENTRIES) ? KNOWN_ENTRIES :
                                  TABLE_ENTRIES;

    logic      front_ready, front_valid;
    t_seg_item front_item;
    logic      mid_full, mid_empty;
    t_seg_item mid_item;
    logic      back_ready, back_valid;
    t_result   back_result;
    logic      out_full;
    t_result   out_result;

    assign full = !front_ready;

    // Front: range check and segment search.
    ttint_front #(
        .USED_ENTRIES(USED_ENTRIES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push),
        .i_ohms  (i_resistance_ohms),
        .o_ready (front_ready),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (!mid_full)
    );

    // Queue between front and back.
    ttint_fifo #(
        .W    ($bits(t_seg_item)),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_valid),
        .i_wr_data (front_item),
        .o_full    (mid_full),
        .i_rd_en   (back_ready),
        .o_empty   (mid_empty),
        .o_rd_data (mid_item)
    );

    // Back: interpolation within the segment.
    ttint_back #(
        .USED_ENTRIES(USED_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!mid_empty),
        .i_item   (mid_item),
        .o_ready  (back_ready),
        .o_valid  (back_valid),
        .o_result (back_result),
        .i_ready  (!out_full)
    );

    // Output queue holding finished results.
    ttint_fifo #(
        .W    ($bits(t_result)),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (back_valid),
        .i_wr_data (back_result),
        .o_full    (out_full),
        .i_rd_en   (pop),
        .o_empty   (empty),
        .o_rd_data (out_result)
    );

    assign o_temperature_c = out_result.temp;
    assign o_range_status  = out_result.status;

endmodule

FILE: verif/thermistor_table_interpolator_tb.sv
module thermistor_table_interpolator_tb;
    import ttint_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_ITEMS     = 400;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int LONG_HOLD_CYCLES = 48;
    localparam int SETTLE_CYCLES    = 12;
    localparam int TIMEOUT_CYCLES   = 200000;

    // Entries in use, clamped the same way as the block clamps its parameter.
    localparam int USED_POINTS = (DEF_TABLE_ENTRIES < 2) ? 2 :
                                 (DEF_TABLE_ENTRIES > KNOWN_ENTRIES) ? KNOWN_ENTRIES :
                                 DEF_TABLE_ENTRIES;

    // Thermistor curve: resistance at every 5 degree step from 0 C.
    localparam logic [OHMS_W-1:0] NTC_OHMS [KNOWN_ENTRIES] = '{
        16'd5743, 16'd4627, 16'd3749, 16'd3053, 16'd2499,
        16'd2056, 16'd1700, 16'd1412, 16'd1178, 16'd987,
        16'd830,  16'd701,  16'd595,  16'd507,  16'd433,
        16'd371,  16'd319,  16'd276,  16'd239,  16'd208,
        16'd181,  16'd158,  16'd139,  16'd122,  16'd108
    };

    // One directed beat; where typed is set the answer is given in the row.
    typedef struct packed {
        logic [OHMS_W-1:0] ohms;
        logic              typed;
        logic [TEMP_W-1:0] temp;
        t_range_status     status;
    } t_probe;

    typedef struct packed {
        logic [OHMS_W-1:0] ohms;
        t_result           answer;
    } t_pending_reading;

    localparam int NUM_PROBES = 22;
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{16'd0,     1'b1, 7'd121, RANGE_HOT},
        '{16'd65535, 1'b1, 7'd0,   RANGE_COLD},
        '{16'd5744,  1'b1, 7'd0,   RANGE_COLD},
        '{16'd5743,  1'b1, 7'd0,   RANGE_OK},
        '{16'd108,   1'b1, 7'd120, RANGE_OK},
        '{16'd107,   1'b1, 7'd121, RANGE_HOT},
        '{16'd4627,  1'b1, 7'd5,   RANGE_OK},
        '{16'd830,   1'b1, 7'd50,  RANGE_OK},
        '{16'd181,   1'b1, 7'd100, RANGE_OK},
        '{16'd122,   1'b1, 7'd115, RANGE_OK},
        '{16'd2056,  1'b1, 7'd25,  RANGE_OK},
        '{16'd32768, 1'b1, 7'd0,   RANGE_COLD},
        '{16'd21845, 1'b1, 7'd0,   RANGE_COLD},
        '{16'd43690, 1'b1, 7'd0,   RANGE_COLD},
        '{16'd1,     1'b1, 7'd121, RANGE_HOT},
        '{16'd5742,  1'b0, 7'd0,   RANGE_OK},
        '{16'd4628,  1'b0, 7'd0,   RANGE_OK},
        '{16'd4626,  1'b0, 7'd0,   RANGE_OK},
        '{16'd109,   1'b0, 7'd0,   RANGE_OK},
        '{16'd1000,  1'b0, 7'd0,   RANGE_OK},
        '{16'd3000,  1'b0, 7'd0,   RANGE_OK},
        '{16'd200,   1'b0, 7'd0,   RANGE_OK}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [OHMS_W-1:0]   i_resistance_ohms;
    logic                empty;
    logic                pop;
    logic [TEMP_W-1:0]   o_temperature_c;
    logic [STATUS_W-1:0] o_range_status;

    t_pending_reading pending_readings [$];
    int               mismatch_count = 0;
    bit               beat_taken     = 1'b0;
    bit               answer_typed   = 1'b0;
    t_result          typed_answer   = '0;
    bit               hold_off_req   = 1'b0;
    bit               draining       = 1'b0;

    thermistor_table_interpolator #(
        .TABLE_ENTRIES (DEF_TABLE_ENTRIES),
        .QUEUE_DEPTH   (DEF_QUEUE_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_resistance_ohms (i_resistance_ohms),
        .empty             (empty),
        .pop               (pop),
        .o_temperature_c   (o_temperature_c),
        .o_range_status    (o_range_status)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Temperature expected for one resistance: clamp outside the curve,
    // otherwise interpolate along the first segment that brackets it.
    function automatic t_result predict_reading(input logic [OHMS_W-1:0] ohms);
        t_result res;
        int      r;
        int      r_hi;
        int      r_lo;
        int      deg_hi;
        bit      found;
        res.temp   = '0;
        res.status = RANGE_OK;
        r          = int'(ohms);
        found      = 1'b0;
        if (r > int'(NTC_OHMS[0])) begin
            res.status = RANGE_COLD;
        end else if (r < int'(NTC_OHMS[USED_POINTS-1])) begin
            res.temp   = TEMP_W'((USED_POINTS - 1) * DEG_STEP + 1);
            res.status = RANGE_HOT;
        end else begin
            for (int seg = 0; seg < USED_POINTS - 1; seg++) begin
                r_hi = int'(NTC_OHMS[seg]);
                r_lo = int'(NTC_OHMS[seg+1]);
                if (!found && r <= r_hi && r >= r_lo) begin
                    found  = 1'b1;
                    deg_hi = seg * DEG_STEP;
                    // A flat segment gives its first temperature without a divide.
                    if (r_hi == r_lo) begin
                        res.temp = TEMP_W'(deg_hi);
                    end else begin
                        res.temp = TEMP_W'(deg_hi + ((r_hi - r) * DEG_STEP) / (r_hi - r_lo));
                    end
                end
            end
        end
        return res;
    endfunction

    // Random resistance, weighted towards the interpolated span of the curve.
    function automatic logic [OHMS_W-1:0] pick_ohms();
        int kind;
        int idx;
        kind = $urandom_range(0, 9);
        idx  = $urandom_range(0, USED_POINTS - 1);
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                return OHMS_W'($urandom_range(NTC_OHMS[USED_POINTS-1], NTC_OHMS[0]));
            end
            6: begin
                return OHMS_W'(int'(NTC_OHMS[idx]) + $urandom_range(0, 2) - 1);
            end
            7: begin
                if ($urandom_range(0, 1) == 0) begin
                    return OHMS_W'($urandom_range(0, NTC_OHMS[USED_POINTS-1] - 1));
                end
                return OHMS_W'($urandom_range(NTC_OHMS[0] + 1, NTC_OHMS[0] + 300));
            end
            default: begin
                return OHMS_W'($urandom_range(0, 16'hFFFF));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Offers one beat and returns at the falling edge after it has been taken.
    task automatic offer_reading(input logic [OHMS_W-1:0] ohms, input bit typed,
                                 input t_result answer);
        push              = 1'b1;
        i_resistance_ohms = ohms;
        answer_typed      = typed;
        typed_answer      = answer;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    task automatic idle_for(input int cycles);
        push = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Both handshakes are sampled here, on the values held before the edge.
    always @(posedge i_clk) begin
        t_pending_reading want;
        beat_taken = 1'b0;
        if (i_rst_n && push && !full) begin
            beat_taken  = 1'b1;
            want.ohms   = i_resistance_ohms;
            want.answer = answer_typed ? typed_answer : predict_reading(i_resistance_ohms);
            pending_readings.push_back(want);
        end
        if (i_rst_n && pop && !empty) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: temp %0d status %0d",
                                          o_temperature_c, o_range_status));
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_c !== want.answer.temp) begin
                    report_mismatch($sformatf("%0d ohms: temperature_c %0d, expected %0d",
                                              want.ohms, o_temperature_c, want.answer.temp));
                end
                if (o_range_status !== want.answer.status) begin
                    report_mismatch($sformatf("%0d ohms: range_status %0d, expected %0d",
                                              want.ohms, o_range_status, want.answer.status));
                end
            end
        end
    end

    // Receiver: stalls on a random pop pattern that is redrawn each time round,
    // with one long hold-off so that the block backs up into its input; pops at every chance while draining.
    initial begin : result_sink
        int             stall_cycles;
        int             slot;
        logic [7:0]     pop_pattern;
        bit             hold_done;
        pop         = 1'b0;
        slot        = 0;
        pop_pattern = '1;
        hold_done   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                pop       = 1'b0;
                for (stall_cycles = 1; stall_cycles < LONG_HOLD_CYCLES; stall_cycles++) begin
                    @(negedge i_clk);
                end
            end else if (draining) begin
                pop = 1'b1;
            end else begin
                if (slot == 0) begin
                    case ($urandom_range(0, 3))
                        0:       pop_pattern = '1;
                        1:       pop_pattern = 8'($urandom & $urandom);
                        default: pop_pattern = 8'($urandom | $urandom);
                    endcase
                end
                pop  = pop_pattern[slot];
                slot = (slot + 1) % 8;
            end
        end
    end

    // Sender: directed rows, a gap-free burst against the hold-off, then
    // random bursts separated by random gaps.
    initial begin : stimulus
        int sent;
        int burst_left;
        push              = 1'b0;
        i_resistance_ohms = '0;
        i_rst_n           = 1'b0;
        // Hold reset, then release it mid-cycle at a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int row = 0; row < NUM_PROBES; row++) begin
            offer_reading(PROBES[row].ohms, PROBES[row].typed,
                          t_result'{PROBES[row].temp, PROBES[row].status});
            if ($urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 3));
            end
        end

        hold_off_req = 1'b1;
        for (sent = 0; sent < PRESSURE_ITEMS; sent++) begin
            offer_reading(pick_ohms(), 1'b0, '0);
        end

        while (sent < RANDOM_ITEMS) begin
            burst_left = $urandom_range(1, 16);
            while (burst_left > 0 && sent < RANDOM_ITEMS) begin
                offer_reading(pick_ohms(), 1'b0, '0);
                burst_left--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 6));
            end
        end

        // Drain the pipeline, then allow for any stray beat to show up.
        push     = 1'b0;
        draining = 1'b1;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
